### rtl/core/three_digit_lcd_segment_mapper_assert.svh
// Assertion macros for the three-digit LCD segment mapper.
// Expects clk and arst_n in the scope of the module that includes this header.
`ifndef THREE_DIGIT_LCD_SEGMENT_MAPPER_ASSERT_SVH
`define THREE_DIGIT_LCD_SEGMENT_MAPPER_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define TDLSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TDLSM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tdlsm_pkg.sv
// Package for the three-digit LCD segment mapper: widths, constants,
// the hex seven-segment font and the per-group LCD bit maps. No dependencies.
package tdlsm_pkg;

	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned MASK_W    = 26;
	localparam int unsigned SAT_W     = 10;
	localparam int unsigned SAT_MAX   = 999;
	localparam int unsigned POS_COUNT = 12;

	// Hex font. Bit 0 is segment d, then c, b, a, f, e, g.
	function automatic logic [6:0] font_hex(input logic [3:0] digit);
		logic [6:0] f;
		case (digit)
			4'h0: f = 7'h3F;
			4'h1: f = 7'h06;
			4'h2: f = 7'h6D;
			4'h3: f = 7'h4F;
			4'h4: f = 7'h56;
			4'h5: f = 7'h5B;
			4'h6: f = 7'h7B;
			4'h7: f = 7'h0E;
			4'h8: f = 7'h7F;
			4'h9: f = 7'h5F;
			4'hA: f = 7'h7E;
			4'hB: f = 7'h73;
			4'hC: f = 7'h39;
			4'hD: f = 7'h67;
			4'hE: f = 7'h79;
			default: f = 7'h78;
		endcase
		return f;
	endfunction

	// Scatter the seven font bits onto the LCD common bits of one position group.
	function automatic logic [MASK_W-1:0] seg_scatter(input logic [1:0] grp,
		input logic [6:0] f);
		logic [MASK_W-1:0] m;
		m = '0;
		case (grp)
			2'd0: begin
				m[5]  = f[0];
				m[6]  = f[1];
				m[9]  = f[2];
				m[11] = f[3];
				m[10] = f[4];
				m[7]  = f[5];
				m[8]  = f[6];
			end
			2'd1: begin
				m[16] = f[0];
				m[15] = f[1];
				m[0]  = f[2];
				m[2]  = f[3];
				m[1]  = f[4];
				m[14] = f[5];
				m[13] = f[6];
			end
			2'd2: begin
				m[25] = f[0];
				m[24] = f[1];
				m[21] = f[2];
				m[19] = f[3];
				m[20] = f[4];
				m[23] = f[5];
				m[22] = f[6];
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

### rtl/core/three_digit_lcd_segment_mapper.sv
// Top level of the three-digit LCD segment mapper.
// Depends on tdlsm_pkg and three_digit_lcd_segment_mapper_assert.svh.
//
// The block takes a value, saturates it to 999, splits it into hundreds, tens
// and ones, encodes each digit with a hex seven-segment font and scatters the
// segments onto the LCD common bits of the digit's position (0 to 11). It returns
// OR masks for the four display words at slots 0, 1, 63 and 62; the caller ORs
// them into display RAM. An item is captured in an input register, decoded by
// one pass of logic and held in a result register, and one item is taken in
// every cycle as long as the output is not stalled.
// The digit split uses reciprocal multiplies by 41 and 205 in that single pass.
// A stalled output holds its result while the input register still takes one
// more item.
module three_digit_lcd_segment_mapper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tdlsm_pkg::VALUE_W-1:0] value,
	input  logic                          hundreds_enable,
	input  logic [tdlsm_pkg::POS_W-1:0]   hundreds_pos,
	input  logic [tdlsm_pkg::POS_W-1:0]   tens_pos,
	input  logic [tdlsm_pkg::POS_W-1:0]   ones_pos,
	input  logic                          force_tens,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tdlsm_pkg::MASK_W-1:0]  mask_word_a,
	output logic [tdlsm_pkg::MASK_W-1:0]  mask_word_b,
	output logic [tdlsm_pkg::MASK_W-1:0]  mask_word_c,
	output logic [tdlsm_pkg::MASK_W-1:0]  mask_word_d
);

	// Input register.
	logic                          valid_s1;
	logic [tdlsm_pkg::VALUE_W-1:0] value_s1;
	logic                          hen_s1;
	logic [tdlsm_pkg::POS_W-1:0]   hpos_s1;
	logic [tdlsm_pkg::POS_W-1:0]   tpos_s1;
	logic [tdlsm_pkg::POS_W-1:0]   opos_s1;
	logic                          ften_s1;

	// Result register.
	logic                          out_valid_q;
	logic [tdlsm_pkg::MASK_W-1:0]  mask_q [4];

	// Flow control.
	logic out_free;
	logic s1_free;
	logic s1_advance;

	// Decode signals.
	logic [tdlsm_pkg::SAT_W-1:0]   sat_v;
	logic [15:0]                   prod_h;
	logic [3:0]                    dig_h;
	logic [tdlsm_pkg::SAT_W-1:0]   h_x100;
	logic [6:0]                    rem_h;
	logic [14:0]                   prod_t;
	logic [3:0]                    dig_t;
	logic [6:0]                    t_x10;
	logic [3:0]                    dig_o;
	logic                          draw_h;
	logic                          draw_t;
	logic [tdlsm_pkg::MASK_W-1:0]  mask_d [4];

	// The output register frees up when it is empty or its transfer completes;
	// the input register moves forward whenever the output can take it.
	assign out_free   = !out_valid_q || !out_stall;
	assign s1_advance = valid_s1 && out_free;
	assign s1_free    = !valid_s1 || out_free;
	assign in_stall   = !s1_free;

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			value_s1 <= value;
			hen_s1   <= hundreds_enable;
			hpos_s1  <= hundreds_pos;
			tpos_s1  <= tens_pos;
			opos_s1  <= ones_pos;
			ften_s1  <= force_tens;
		end
	end

	// Saturate and split into digits with reciprocal multiplies.
	always_comb begin
		if (value_s1 > tdlsm_pkg::VALUE_W'(tdlsm_pkg::SAT_MAX)) begin
			sat_v = tdlsm_pkg::SAT_W'(tdlsm_pkg::SAT_MAX);
		end else begin
			sat_v = value_s1[tdlsm_pkg::SAT_W-1:0];
		end
		prod_h = 16'(sat_v) * 16'd41;
		dig_h  = prod_h[15:12];
		h_x100 = tdlsm_pkg::SAT_W'(dig_h) * tdlsm_pkg::SAT_W'(100);
		rem_h  = 7'(sat_v - h_x100);
		prod_t = 15'(rem_h) * 15'd205;
		dig_t  = prod_t[14:11];
		t_x10  = 7'(dig_t) * 7'd10;
		dig_o  = 4'(rem_h - t_x10);
		draw_h = hen_s1 && (sat_v > tdlsm_pkg::SAT_W'(99));
		draw_t = ften_s1 || (sat_v > tdlsm_pkg::SAT_W'(9));
	end

	// Scatter each drawn digit into the word its position selects.
	always_comb begin
		for (int w = 0; w < 4; w++) begin
			mask_d[w] = '0;
		end
		if (draw_h && (hpos_s1 < tdlsm_pkg::POS_W'(tdlsm_pkg::POS_COUNT))) begin
			mask_d[hpos_s1[1:0]] = mask_d[hpos_s1[1:0]]
				| tdlsm_pkg::seg_scatter(hpos_s1[3:2], tdlsm_pkg::font_hex(dig_h));
		end
		if (draw_t && (tpos_s1 < tdlsm_pkg::POS_W'(tdlsm_pkg::POS_COUNT))) begin
			mask_d[tpos_s1[1:0]] = mask_d[tpos_s1[1:0]]
				| tdlsm_pkg::seg_scatter(tpos_s1[3:2], tdlsm_pkg::font_hex(dig_t));
		end
		if (opos_s1 < tdlsm_pkg::POS_W'(tdlsm_pkg::POS_COUNT)) begin
			mask_d[opos_s1[1:0]] = mask_d[opos_s1[1:0]]
				| tdlsm_pkg::seg_scatter(opos_s1[3:2], tdlsm_pkg::font_hex(dig_o));
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_advance) begin
			for (int w = 0; w < 4; w++) begin
				mask_q[w] <= mask_d[w];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign mask_word_a = mask_q[0];
	assign mask_word_b = mask_q[1];
	assign mask_word_c = mask_q[2];
	assign mask_word_d = mask_q[3];

	// Assertions.
`include "three_digit_lcd_segment_mapper_assert.svh"
	`TDLSM_ASSERT(a_stall_only_when_full, in_stall |-> (valid_s1 && out_valid_q && out_stall), "input stalled while a register is free")
	`TDLSM_ASSERT(a_transfer_lands_in_s1, (in_valid && !in_stall) |=> valid_s1, "input transfer lost before the decode stage")
	`TDLSM_ASSERT(a_s1_holds, (valid_s1 && !s1_advance) |=> (valid_s1 && $stable(value_s1) && $stable(opos_s1)), "blocked input register changed")
	`TDLSM_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!out_valid && !valid_s1), "pipeline not empty in reset")

endmodule

### tb/tdlsm_checker.sv
// Result checker for the three-digit LCD segment mapper testbench.
// Watches both channels of the block, predicts the four word masks and compares them.
// Depends on tdlsm_pkg for widths and the saturation limit.
module tdlsm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tdlsm_pkg::VALUE_W-1:0] value,
	input  logic                          hundreds_enable,
	input  logic [tdlsm_pkg::POS_W-1:0]   hundreds_pos,
	input  logic [tdlsm_pkg::POS_W-1:0]   tens_pos,
	input  logic [tdlsm_pkg::POS_W-1:0]   ones_pos,
	input  logic                          force_tens,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tdlsm_pkg::MASK_W-1:0]  mask_word_a,
	input  logic [tdlsm_pkg::MASK_W-1:0]  mask_word_b,
	input  logic [tdlsm_pkg::MASK_W-1:0]  mask_word_c,
	input  logic [tdlsm_pkg::MASK_W-1:0]  mask_word_d,
	output int                            fail_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// Index 0 is the word at slot 0, then slots 1, 63 and 62.
	typedef logic [3:0][tdlsm_pkg::MASK_W-1:0] word_masks_t;

	// Hex glyphs. Bit 0 is segment d, then c, b, a, f, e, g.
	localparam logic [0:15][6:0] GLYPH = {
		7'h3F, 7'h06, 7'h6D, 7'h4F, 7'h56, 7'h5B, 7'h7B, 7'h0E,
		7'h7F, 7'h5F, 7'h7E, 7'h73, 7'h39, 7'h67, 7'h79, 7'h78
	};

	// LCD common bit that each glyph bit lands on, per group of four positions.
	localparam logic [0:2][0:6][4:0] LCD_BIT = {
		5'd5,  5'd6,  5'd9,  5'd11, 5'd10, 5'd7,  5'd8,
		5'd16, 5'd15, 5'd0,  5'd2,  5'd1,  5'd14, 5'd13,
		5'd25, 5'd24, 5'd21, 5'd19, 5'd20, 5'd23, 5'd22
	};

	word_masks_t pending_masks[$];
	int          errors;

	// OR one digit into the word that its position selects.
	function automatic word_masks_t light_digit(input word_masks_t acc,
		input logic [tdlsm_pkg::POS_W-1:0] pos, input int unsigned digit);
		logic [6:0] glyph;
		glyph = GLYPH[digit[3:0]];
		if (pos < tdlsm_pkg::POS_COUNT) begin
			for (int s = 0; s < 7; s++) begin
				if (glyph[s])
					acc[pos[1:0]][LCD_BIT[pos[3:2]][s]] = 1'b1;
			end
		end
		return acc;
	endfunction

	// Masks for one transfer: saturate, split into digits, blank leading digits.
	function automatic word_masks_t predict_lcd_masks(
		input logic [tdlsm_pkg::VALUE_W-1:0] raw,
		input logic en_hundreds, input logic [tdlsm_pkg::POS_W-1:0] h_pos,
		input logic [tdlsm_pkg::POS_W-1:0] t_pos,
		input logic [tdlsm_pkg::POS_W-1:0] o_pos,
		input logic keep_tens);
		int unsigned shown;
		word_masks_t m;
		shown = (raw > tdlsm_pkg::SAT_MAX) ? tdlsm_pkg::SAT_MAX : 32'(raw);
		m = '0;
		if (en_hundreds && shown > 99)
			m = light_digit(m, h_pos, shown / 100);
		if (keep_tens || shown > 9)
			m = light_digit(m, t_pos, (shown % 100) / 10);
		m = light_digit(m, o_pos, shown % 10);
		return m;
	endfunction

	// Compare each result transfer with the oldest prediction, then queue the new one.
	always @(posedge clk) begin
		word_masks_t got;
		word_masks_t want;
		if (!arst_n) begin
			pending_masks.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {mask_word_d, mask_word_c, mask_word_b, mask_word_a};
				if (pending_masks.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t ns: result transfer with none expected: %h %h %h %h",
							$time, got[0], got[1], got[2], got[3]);
				end else begin
					want = pending_masks.pop_front();
					for (int w = 0; w < 4; w++) begin
						if (got[w] !== want[w]) begin
							errors++;
							if (errors <= REPORT_LIMIT)
								$display("%0t ns: mask word %0d mismatch, expected %h, got %h",
									$time, w, want[w], got[w]);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				pending_masks.push_back(predict_lcd_masks(value, hundreds_enable,
					hundreds_pos, tens_pos, ones_pos, force_tens));
			fail_count <= errors;
			outstanding <= pending_masks.size();
		end
	end

endmodule

### tb/testbench.sv
// Top of the testbench for the three-digit LCD segment mapper.
// Drives directed and random values with random gaps and output stalls; the verdict
// comes from tdlsm_checker. Depends on tdlsm_pkg and the block itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1150;
	localparam int TAIL_CYCLES  = 8;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [tdlsm_pkg::VALUE_W-1:0] value;
	logic                          hundreds_enable;
	logic [tdlsm_pkg::POS_W-1:0]   hundreds_pos;
	logic [tdlsm_pkg::POS_W-1:0]   tens_pos;
	logic [tdlsm_pkg::POS_W-1:0]   ones_pos;
	logic                          force_tens;
	logic                          out_valid;
	logic                          out_stall;
	logic [tdlsm_pkg::MASK_W-1:0]  mask_word_a;
	logic [tdlsm_pkg::MASK_W-1:0]  mask_word_b;
	logic [tdlsm_pkg::MASK_W-1:0]  mask_word_c;
	logic [tdlsm_pkg::MASK_W-1:0]  mask_word_d;
	int                            fail_count;
	int                            outstanding;

	three_digit_lcd_segment_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value(value), .hundreds_enable(hundreds_enable),
		.hundreds_pos(hundreds_pos), .tens_pos(tens_pos), .ones_pos(ones_pos),
		.force_tens(force_tens),
		.out_valid(out_valid), .out_stall(out_stall),
		.mask_word_a(mask_word_a), .mask_word_b(mask_word_b),
		.mask_word_c(mask_word_c), .mask_word_d(mask_word_d)
	);

	tdlsm_checker mask_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value(value), .hundreds_enable(hundreds_enable),
		.hundreds_pos(hundreds_pos), .tens_pos(tens_pos), .ones_pos(ones_pos),
		.force_tens(force_tens),
		.out_valid(out_valid), .out_stall(out_stall),
		.mask_word_a(mask_word_a), .mask_word_b(mask_word_b),
		.mask_word_c(mask_word_c), .mask_word_d(mask_word_d),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// Free-running 12 ns clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the whole run.
	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	// Output stalls: free stretches, mostly short, sometimes long, then short or long stalls.
	initial begin : stall_gen
		int free_len;
		int hold_len;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 6);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			out_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
			out_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
		end
	end

	// A random display position among the twelve that exist.
	function automatic logic [tdlsm_pkg::POS_W-1:0] rand_pos();
		return tdlsm_pkg::POS_W'($urandom_range(0, 11));
	endfunction

	// Present one value and hold it until the block takes the transfer.
	task automatic send_digits(input logic [tdlsm_pkg::VALUE_W-1:0] v,
		input logic en_hundreds, input logic [tdlsm_pkg::POS_W-1:0] h_pos,
		input logic [tdlsm_pkg::POS_W-1:0] t_pos,
		input logic [tdlsm_pkg::POS_W-1:0] o_pos, input logic keep_tens);
		in_valid <= 1'b1;
		value <= v;
		hundreds_enable <= en_hundreds;
		hundreds_pos <= h_pos;
		tens_pos <= t_pos;
		ones_pos <= o_pos;
		force_tens <= keep_tens;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Hold off the sender until every predicted result has come back.
	task automatic await_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// Reset, directed values, random values, then the verdict.
	initial begin : stimulus
		int gap;
		logic [tdlsm_pkg::VALUE_W-1:0] v;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		hundreds_enable <= 1'b0;
		hundreds_pos <= '0;
		tens_pos <= '0;
		ones_pos <= '0;
		force_tens <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero with and without a forced tens digit, then the blanking thresholds.
		send_digits(16'd0, 1'b1, 4'd8, 4'd4, 4'd0, 1'b0);
		send_digits(16'd0, 1'b1, 4'd8, 4'd4, 4'd0, 1'b1);
		send_digits(16'd9, 1'b1, 4'd2, 4'd1, 4'd0, 1'b0);
		send_digits(16'd10, 1'b1, 4'd2, 4'd1, 4'd0, 1'b0);
		send_digits(16'd99, 1'b1, 4'd2, 4'd1, 4'd0, 1'b0);
		send_digits(16'd100, 1'b1, 4'd2, 4'd1, 4'd0, 1'b0);
		send_digits(16'd100, 1'b0, 4'd2, 4'd1, 4'd0, 1'b0);
		// Saturation and the top of the value range.
		send_digits(16'd999, 1'b1, 4'd11, 4'd7, 4'd3, 1'b0);
		send_digits(16'd1000, 1'b1, 4'd0, 4'd1, 4'd2, 1'b1);
		send_digits(16'hFFFF, 1'b1, 4'd8, 4'd9, 4'd10, 1'b1);
		send_digits(16'h8000, 1'b1, 4'd4, 4'd5, 4'd6, 1'b0);
		send_digits(16'd12345, 1'b0, 4'd6, 4'd7, 4'd4, 1'b0);
		// Digits sharing one word, and all three on a single position.
		send_digits(16'd555, 1'b1, 4'd0, 4'd4, 4'd8, 1'b0);
		send_digits(16'd777, 1'b1, 4'd5, 4'd5, 4'd5, 1'b1);
		send_digits(16'd50, 1'b1, 4'd11, 4'd11, 4'd11, 1'b0);
		// Every decimal digit value, and every position group.
		send_digits(16'd123, 1'b1, 4'd3, 4'd7, 4'd11, 1'b0);
		send_digits(16'd456, 1'b1, 4'd1, 4'd2, 4'd3, 1'b1);
		send_digits(16'd789, 1'b1, 4'd9, 4'd10, 4'd11, 1'b0);
		send_digits(16'd808, 1'b1, 4'd6, 4'd0, 4'd9, 1'b0);
		send_digits(16'd1, 1'b0, 4'd0, 4'd0, 4'd0, 1'b1);
		send_digits(16'd246, 1'b1, 4'd3, 4'd2, 4'd1, 1'b0);
		send_digits(16'h5555, 1'b1, 4'd7, 4'd6, 4'd5, 1'b1);
		send_digits(16'h2AAA, 1'b0, 4'd4, 4'd0, 4'd8, 1'b0);
		await_all_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Weight toward values that keep every blanking rule in play.
			case ($urandom_range(0, 9))
				0: v = tdlsm_pkg::VALUE_W'($urandom_range(0, 9));
				1, 2: v = tdlsm_pkg::VALUE_W'($urandom_range(10, 99));
				3, 4, 5, 6: v = tdlsm_pkg::VALUE_W'($urandom_range(100, 999));
				7: v = tdlsm_pkg::VALUE_W'($urandom_range(1000, 65535));
				8: v = tdlsm_pkg::VALUE_W'($urandom);
				default: begin
					case ($urandom_range(0, 3))
						0: v = 16'd999;
						1: v = 16'd1000;
						2: v = 16'hFFFF;
						default: v = 16'd100;
					endcase
				end
			endcase
			send_digits(v, $urandom_range(0, 3) != 0, rand_pos(), rand_pos(), rand_pos(),
				$urandom_range(0, 1) != 0);

			// Back-to-back stretches, then short gaps with an occasional long one.
			if (n == RANDOM_ITEMS / 2) begin
				await_all_results();
			end else begin
				if (n % 200 < 40)
					gap = 0;
				else if ($urandom_range(0, 9) < 5)
					gap = 0;
				else if ($urandom_range(0, 9) < 8)
					gap = $urandom_range(1, 3);
				else
					gap = $urandom_range(10, 40);
				idle_sender(gap);
			end
		end

		await_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
